/* rtl/core/ccst_pkg.sv */
`timescale 1ns / 1ps

package ccst_pkg;

    localparam int CHAR_WIDTH = 16;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int MAX_EVENTS = 3;

    localparam logic [CHAR_WIDTH-1:0] CH_LPAREN = CHAR_WIDTH'('h28);
    localparam logic [CHAR_WIDTH-1:0] CH_RPAREN = CHAR_WIDTH'('h29);
    localparam logic [CHAR_WIDTH-1:0] CH_SEMI   = CHAR_WIDTH'('h3B);
    localparam logic [CHAR_WIDTH-1:0] CH_QUOTE  = CHAR_WIDTH'('h22);
    localparam logic [CHAR_WIDTH-1:0] CH_BSLASH = CHAR_WIDTH'('h5C);
    localparam logic [CHAR_WIDTH-1:0] CH_COMMA  = CHAR_WIDTH'('h2C);

    localparam logic [2:0] EV_NAME_CHAR = 3'd0;
    localparam logic [2:0] EV_NAME_DONE = 3'd1;
    localparam logic [2:0] EV_ARG_BEGIN = 3'd2;
    localparam logic [2:0] EV_ARG_CHAR  = 3'd3;
    localparam logic [2:0] EV_ARG_END   = 3'd4;
    localparam logic [2:0] EV_CMD_END   = 3'd5;
    localparam logic [2:0] EV_PARSE_END = 3'd6;

    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_NO_OPEN  = 3'd1;
    localparam logic [2:0] ERR_NO_CLOSE = 3'd2;
    localparam logic [2:0] ERR_NO_SEMI  = 3'd3;
    localparam logic [2:0] ERR_STRAY    = 3'd4;

    typedef struct packed {
        logic [2:0]            kind;
        logic [CHAR_WIDTH-1:0] ch;
        logic [2:0]            err;
    } event_t;

    // all events caused by one input character
    typedef struct packed {
        logic [1:0]                  cnt;
        event_t [MAX_EVENTS-1:0]     ev;
    } bundle_t;

    function automatic logic is_space(input logic [CHAR_WIDTH-1:0] c);
        return (c == CHAR_WIDTH'('h20)) || (c >= CHAR_WIDTH'('h09) && c <= CHAR_WIDTH'('h0D));
    endfunction

    function automatic logic is_alpha(input logic [CHAR_WIDTH-1:0] c);
        return (c >= CHAR_WIDTH'('h41) && c <= CHAR_WIDTH'('h5A))
            || (c >= CHAR_WIDTH'('h61) && c <= CHAR_WIDTH'('h7A));
    endfunction

endpackage

/* rtl/core/ccst_front.sv */
`timescale 1ns / 1ps

module ccst_front
    import ccst_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  accept,
    input  logic [CHAR_WIDTH-1:0] char_code,
    input  logic                  end_of_text,
    output logic                  bundle_valid,
    output bundle_t               bundle
);

    typedef enum logic [6:0] {
        PH_IDLE  = 7'b0000001,
        PH_NAME  = 7'b0000010,
        PH_ARGS  = 7'b0000100,
        PH_STR   = 7'b0001000,
        PH_STRBS = 7'b0010000,
        PH_CLOSE = 7'b0100000,
        PH_ERR   = 7'b1000000
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [2:0] err_reg, err_next;

    always_comb
    begin
        logic [1:0] n;
        n          = 2'd0;
        bundle     = '0;
        phase_next = phase_reg;
        err_next   = err_reg;

        unique case (phase_reg)
            PH_IDLE:
            begin
                if (is_space(char_code))
                begin
                end
                else if (is_alpha(char_code))
                begin
                    bundle.ev[n] = '{EV_NAME_CHAR, char_code, ERR_NONE};
                    n = n + 2'd1;
                    phase_next = PH_NAME;
                end
                else
                begin
                    if (err_next == ERR_NONE) err_next = ERR_NO_OPEN;
                    phase_next = PH_ERR;
                end
            end
            PH_NAME:
            begin
                if (is_alpha(char_code))
                begin
                    bundle.ev[n] = '{EV_NAME_CHAR, char_code, ERR_NONE};
                    n = n + 2'd1;
                end
                else if (char_code == CH_LPAREN)
                begin
                    bundle.ev[n] = '{EV_NAME_DONE, '0, ERR_NONE};
                    n = n + 2'd1;
                    phase_next = PH_ARGS;
                end
                else
                begin
                    if (err_next == ERR_NONE) err_next = ERR_NO_OPEN;
                    phase_next = PH_ERR;
                end
            end
            PH_ARGS:
            begin
                if (is_space(char_code) || char_code == CH_COMMA)
                begin
                end
                else if (char_code == CH_QUOTE)
                begin
                    bundle.ev[n] = '{EV_ARG_BEGIN, '0, ERR_NONE};
                    n = n + 2'd1;
                    phase_next = PH_STR;
                end
                else if (char_code == CH_RPAREN)
                begin
                    phase_next = PH_CLOSE;
                end
                else
                begin
                    if (err_next == ERR_NONE) err_next = ERR_STRAY;
                    phase_next = PH_ERR;
                end
            end
            PH_STR, PH_STRBS:
            begin
                if (phase_reg == PH_STRBS && char_code == CH_QUOTE)
                begin
                    // escaped quote
                    bundle.ev[n] = '{EV_ARG_CHAR, CH_QUOTE, ERR_NONE};
                    n = n + 2'd1;
                    phase_next = PH_STR;
                end
                else
                begin
                    if (phase_reg == PH_STRBS)
                    begin
                        // lone backslash stays literal
                        bundle.ev[n] = '{EV_ARG_CHAR, CH_BSLASH, ERR_NONE};
                        n = n + 2'd1;
                    end
                    if (char_code == CH_QUOTE)
                    begin
                        bundle.ev[n] = '{EV_ARG_END, '0, ERR_NONE};
                        n = n + 2'd1;
                        phase_next = PH_ARGS;
                    end
                    else if (char_code == CH_BSLASH)
                    begin
                        phase_next = PH_STRBS;
                    end
                    else
                    begin
                        bundle.ev[n] = '{EV_ARG_CHAR, char_code, ERR_NONE};
                        n = n + 2'd1;
                        phase_next = PH_STR;
                    end
                end
            end
            PH_CLOSE:
            begin
                if (is_space(char_code))
                begin
                end
                else if (char_code == CH_SEMI)
                begin
                    bundle.ev[n] = '{EV_CMD_END, '0, ERR_NONE};
                    n = n + 2'd1;
                    phase_next = PH_IDLE;
                end
                else
                begin
                    if (err_next == ERR_NONE) err_next = ERR_NO_SEMI;
                    phase_next = PH_ERR;
                end
            end
            default:
            begin
                phase_next = PH_ERR;
            end
        endcase

        if (end_of_text)
        begin
            unique case (phase_next)
                PH_NAME:
                begin
                    if (err_next == ERR_NONE) err_next = ERR_NO_OPEN;
                end
                PH_ARGS, PH_STR:
                begin
                    if (err_next == ERR_NONE) err_next = ERR_NO_CLOSE;
                end
                PH_STRBS:
                begin
                    bundle.ev[n] = '{EV_ARG_CHAR, CH_BSLASH, ERR_NONE};
                    n = n + 2'd1;
                    if (err_next == ERR_NONE) err_next = ERR_NO_CLOSE;
                end
                PH_CLOSE:
                begin
                    if (err_next == ERR_NONE) err_next = ERR_NO_SEMI;
                end
                default:
                begin
                end
            endcase
            bundle.ev[n] = '{EV_PARSE_END, '0, err_next};
            n = n + 2'd1;
            phase_next = PH_IDLE;
            err_next   = ERR_NONE;
        end

        bundle.cnt   = n;
        bundle_valid = accept && (n != 2'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            err_reg   <= ERR_NONE;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            err_reg   <= err_next;
        end
    end

endmodule

/* rtl/core/ccst_queue.sv */
`timescale 1ns / 1ps

module ccst_queue
    import ccst_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    wr_en,
    input  bundle_t wr_data,
    input  logic    rd_en,
    output bundle_t rd_data,
    output logic    q_full,
    output logic    q_empty
);

    bundle_t           mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   count_reg, count_next;

    assign q_full  = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign q_empty = (count_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + QPTR_W'(wr_en);
        rd_ptr_next = rd_ptr_reg + QPTR_W'(rd_en);
        count_next  = count_reg + (QPTR_W+1)'(wr_en) - (QPTR_W+1)'(rd_en);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

/* rtl/core/ccst_back.sv */
`timescale 1ns / 1ps

module ccst_back
    import ccst_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  bundle_t               head,
    input  logic                  q_empty,
    input  logic                  pop,
    output logic                  deq,
    output logic [2:0]            event_kind,
    output logic [CHAR_WIDTH-1:0] char_out,
    output logic [2:0]            error_code,
    output logic                  final_res
);

    logic [1:0] idx_reg, idx_next;
    event_t     cur;
    logic       take;

    assign cur        = head.ev[idx_reg];
    assign event_kind = cur.kind;
    assign char_out   = cur.ch;
    assign error_code = cur.err;
    assign final_res  = (idx_reg == head.cnt - 2'd1);
    assign take       = pop && !q_empty;
    // release the bundle once its last event transfers
    assign deq        = take && final_res;

    always_comb
    begin
        idx_next = idx_reg;
        if (take)
        begin
            idx_next = final_res ? 2'd0 : idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= 2'd0;
        end
        else
        begin
            idx_reg <= idx_next;
        end
    end

endmodule

/* rtl/core/command_call_syntax_tokenizer.sv */
// Channel   | Direction | Transfer when    | Payload
// ----------+-----------+------------------+---------------------------------------------
// input     | in        | push && !full    | char_code, end_of_text
// result    | out       | pop && !empty    | event_kind, char_out, error_code, final_res
//
// One character is taken per cycle while the queue is not full; the front parser updates
// its phase in that cycle and writes one to three events as one bundle into a four-entry
// queue (none for a character with no events). Results leave one per cycle while pop is
// high, so a character with three events holds the back end for three transfers; full
// rises only when the queue holds four pending bundles. Reset (rst_n low, asynchronous)
// returns the parser to idle with no error and empties the queue.
`timescale 1ns / 1ps

module command_call_syntax_tokenizer
    import ccst_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic [CHAR_WIDTH-1:0] char_code,
    input  logic                  end_of_text,
    output logic                  empty,
    input  logic                  pop,
    output logic [2:0]            event_kind,
    output logic [CHAR_WIDTH-1:0] char_out,
    output logic [2:0]            error_code,
    output logic                  final_res
);

    logic    accept;
    logic    bundle_valid;
    bundle_t bundle;
    bundle_t head;
    logic    q_full;
    logic    q_empty;
    logic    deq;

    assign accept = push && !q_full;
    assign full   = q_full;
    assign empty  = q_empty;

    ccst_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .char_code    (char_code),
        .end_of_text  (end_of_text),
        .bundle_valid (bundle_valid),
        .bundle       (bundle)
    );

    ccst_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (bundle_valid),
        .wr_data (bundle),
        .rd_en   (deq),
        .rd_data (head),
        .q_full  (q_full),
        .q_empty (q_empty)
    );

    ccst_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .q_empty    (q_empty),
        .pop        (pop),
        .deq        (deq),
        .event_kind (event_kind),
        .char_out   (char_out),
        .error_code (error_code),
        .final_res  (final_res)
    );

endmodule

/* rtl/core/ccst_checker.sv */
`timescale 1ns / 1ps

module ccst_checker
    import ccst_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  empty,
    input logic                  pop,
    input logic [2:0]            event_kind,
    input logic [CHAR_WIDTH-1:0] char_out,
    input logic [2:0]            error_code,
    input logic                  final_res
);

    // parse end always closes the events of its character
    a_parse_end_final: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && event_kind == EV_PARSE_END) |-> final_res)
        else $error("parse end not marked final");

    a_char_only_on_chars: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && event_kind != EV_NAME_CHAR && event_kind != EV_ARG_CHAR)
        |-> (char_out == '0))
        else $error("character on non-character event");

    a_err_only_on_end: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && event_kind != EV_PARSE_END) |-> (error_code == ERR_NONE))
        else $error("error code outside parse end");

    a_err_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (error_code == ERR_NONE || error_code == ERR_NO_OPEN
                    || error_code == ERR_NO_CLOSE || error_code == ERR_NO_SEMI
                    || error_code == ERR_STRAY))
        else $error("error code out of range");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(event_kind) && $stable(char_out)
                             && $stable(final_res)))
        else $error("stalled result changed");

endmodule

bind command_call_syntax_tokenizer ccst_checker u_ccst_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .empty      (empty),
    .pop        (pop),
    .event_kind (event_kind),
    .char_out   (char_out),
    .error_code (error_code),
    .final_res  (final_res)
);

/* dv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
    import ccst_pkg::*;

    typedef enum logic [2:0] {
        P_IDLE,
        P_NAME,
        P_ARGS,
        P_STR,
        P_STR_ESC,
        P_CLOSED,
        P_ERROR
    } phase_e;

    typedef struct packed {
        logic [2:0]            kind;
        logic [CHAR_WIDTH-1:0] ch;
        logic [2:0]            err;
        logic                  fin;
    } token_t;

    typedef struct packed {
        logic [CHAR_WIDTH-1:0] code;
        logic                  eot;
        logic                  typed;
        token_t                tok;
    } stim_row_t;

    localparam token_t NO_TOKEN = '0;

    // Rows with typed set produce exactly the one token given; the rest go to the predictor.
    localparam stim_row_t SCRIPT [29] = '{
        '{16'h0061,  1'b0, 1'b1, '{EV_NAME_CHAR, 16'h0061, ERR_NONE, 1'b1}},
        '{CH_LPAREN, 1'b0, 1'b1, '{EV_NAME_DONE, 16'h0000, ERR_NONE, 1'b1}},
        '{16'h0020,  1'b0, 1'b0, NO_TOKEN},
        '{CH_QUOTE,  1'b0, 1'b0, NO_TOKEN},
        '{CH_BSLASH, 1'b0, 1'b0, NO_TOKEN},
        '{CH_QUOTE,  1'b0, 1'b0, NO_TOKEN},
        '{CH_BSLASH, 1'b0, 1'b0, NO_TOKEN},
        '{16'hFFFF,  1'b0, 1'b0, NO_TOKEN},
        '{CH_QUOTE,  1'b0, 1'b0, NO_TOKEN},
        '{CH_COMMA,  1'b0, 1'b0, NO_TOKEN},
        '{CH_RPAREN, 1'b0, 1'b0, NO_TOKEN},
        '{CH_SEMI,   1'b1, 1'b0, NO_TOKEN},
        // non-letter where a name should begin
        '{16'h0000,  1'b1, 1'b1, '{EV_PARSE_END, 16'h0000, ERR_NO_OPEN, 1'b1}},
        // whitespace between name and open paren, then ignored input
        '{16'h005A,  1'b0, 1'b1, '{EV_NAME_CHAR, 16'h005A, ERR_NONE, 1'b1}},
        '{16'h0009,  1'b0, 1'b0, NO_TOKEN},
        '{CH_LPAREN, 1'b1, 1'b1, '{EV_PARSE_END, 16'h0000, ERR_NO_OPEN, 1'b1}},
        // text ends inside a string on a pending backslash
        '{16'h007A,  1'b0, 1'b0, NO_TOKEN},
        '{CH_LPAREN, 1'b0, 1'b0, NO_TOKEN},
        '{CH_QUOTE,  1'b0, 1'b0, NO_TOKEN},
        '{CH_BSLASH, 1'b1, 1'b0, NO_TOKEN},
        // stray character in the argument list
        '{16'h0041,  1'b0, 1'b0, NO_TOKEN},
        '{CH_LPAREN, 1'b0, 1'b0, NO_TOKEN},
        '{16'h006B,  1'b1, 1'b1, '{EV_PARSE_END, 16'h0000, ERR_STRAY, 1'b1}},
        // text ends inside a name
        '{16'h0071,  1'b1, 1'b0, NO_TOKEN},
        // text ends inside the argument list
        '{16'h006D,  1'b0, 1'b0, NO_TOKEN},
        '{CH_LPAREN, 1'b1, 1'b0, NO_TOKEN},
        // text ends after the close paren
        '{16'h0068,  1'b0, 1'b0, NO_TOKEN},
        '{CH_LPAREN, 1'b0, 1'b0, NO_TOKEN},
        '{CH_RPAREN, 1'b1, 1'b1, '{EV_PARSE_END, 16'h0000, ERR_NO_SEMI, 1'b1}}
    };

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  push = 1'b0;
    logic                  full;
    logic [CHAR_WIDTH-1:0] char_code = '0;
    logic                  end_of_text = 1'b0;
    logic                  empty;
    logic                  pop = 1'b0;
    logic [2:0]            event_kind;
    logic [CHAR_WIDTH-1:0] char_out;
    logic [2:0]            error_code;
    logic                  final_res;

    logic                  drv_typed = 1'b0;
    token_t                drv_token = '0;

    phase_e                tok_phase = P_IDLE;
    logic [2:0]            tok_err = ERR_NONE;
    token_t                char_tokens[$];
    token_t                tokens_due[$];
    logic [CHAR_WIDTH-1:0] line_chars[$];

    int                    live_chars = 0;
    int                    mismatches = 0;
    int                    burst_left = 0;
    logic [15:0]           rx_tick = '0;

    command_call_syntax_tokenizer dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .char_code   (char_code),
        .end_of_text (end_of_text),
        .empty       (empty),
        .pop         (pop),
        .event_kind  (event_kind),
        .char_out    (char_out),
        .error_code  (error_code),
        .final_res   (final_res)
    );

    always #2 clk = ~clk;

    // ---------------- token predictor ----------------

    function automatic logic is_blank_char(input logic [CHAR_WIDTH-1:0] c);
        return c == CHAR_WIDTH'('h20) || (c >= CHAR_WIDTH'('h09) && c <= CHAR_WIDTH'('h0D));
    endfunction

    function automatic logic is_letter_char(input logic [CHAR_WIDTH-1:0] c);
        return (c >= CHAR_WIDTH'('h41) && c <= CHAR_WIDTH'('h5A))
            || (c >= CHAR_WIDTH'('h61) && c <= CHAR_WIDTH'('h7A));
    endfunction

    function automatic void add_char(input logic [CHAR_WIDTH-1:0] c);
        line_chars.insert(line_chars.size(), c);
    endfunction

    function automatic void post_token(input logic [2:0] kind, input logic [CHAR_WIDTH-1:0] ch,
                                       input logic [2:0] err);
        char_tokens.insert(char_tokens.size(), token_t'{kind, ch, err, 1'b0});
    endfunction

    function automatic void flag_error(input logic [2:0] code);
        if (tok_err == ERR_NONE)
            tok_err = code;
        tok_phase = P_ERROR;
    endfunction

    function automatic void take_string_char(input logic [CHAR_WIDTH-1:0] c);
        if (c == CH_QUOTE) begin
            post_token(EV_ARG_END, '0, ERR_NONE);
            tok_phase = P_ARGS;
        end
        else if (c == CH_BSLASH) begin
            tok_phase = P_STR_ESC;
        end
        else begin
            post_token(EV_ARG_CHAR, c, ERR_NONE);
        end
    endfunction

    function automatic void tokenize_char(input logic [CHAR_WIDTH-1:0] c, input logic eot);
        char_tokens.delete();
        case (tok_phase)
            P_IDLE:
                if (is_letter_char(c)) begin
                    post_token(EV_NAME_CHAR, c, ERR_NONE);
                    tok_phase = P_NAME;
                end
                else if (!is_blank_char(c)) begin
                    flag_error(ERR_NO_OPEN);
                end
            P_NAME:
                if (is_letter_char(c)) begin
                    post_token(EV_NAME_CHAR, c, ERR_NONE);
                end
                else if (c == CH_LPAREN) begin
                    post_token(EV_NAME_DONE, '0, ERR_NONE);
                    tok_phase = P_ARGS;
                end
                else begin
                    flag_error(ERR_NO_OPEN);
                end
            P_ARGS:
                if (c == CH_QUOTE) begin
                    post_token(EV_ARG_BEGIN, '0, ERR_NONE);
                    tok_phase = P_STR;
                end
                else if (c == CH_RPAREN) begin
                    tok_phase = P_CLOSED;
                end
                else if (!is_blank_char(c) && c != CH_COMMA) begin
                    flag_error(ERR_STRAY);
                end
            P_STR:
                take_string_char(c);
            P_STR_ESC:
                if (c == CH_QUOTE) begin
                    post_token(EV_ARG_CHAR, CH_QUOTE, ERR_NONE);
                    tok_phase = P_STR;
                end
                else begin
                    // lone backslash stays literal
                    post_token(EV_ARG_CHAR, CH_BSLASH, ERR_NONE);
                    tok_phase = P_STR;
                    take_string_char(c);
                end
            P_CLOSED:
                if (c == CH_SEMI) begin
                    post_token(EV_CMD_END, '0, ERR_NONE);
                    tok_phase = P_IDLE;
                end
                else if (!is_blank_char(c)) begin
                    flag_error(ERR_NO_SEMI);
                end
            default:
                tok_phase = P_ERROR;
        endcase

        if (eot) begin
            case (tok_phase)
                P_NAME:
                    flag_error(ERR_NO_OPEN);
                P_ARGS, P_STR:
                    flag_error(ERR_NO_CLOSE);
                P_STR_ESC:
                    begin
                        post_token(EV_ARG_CHAR, CH_BSLASH, ERR_NONE);
                        flag_error(ERR_NO_CLOSE);
                    end
                P_CLOSED:
                    flag_error(ERR_NO_SEMI);
                default:
                    ;
            endcase
            post_token(EV_PARSE_END, '0, tok_err);
            tok_phase = P_IDLE;
            tok_err = ERR_NONE;
        end

        if (char_tokens.size() > 0)
            char_tokens[char_tokens.size() - 1].fin = 1'b1;
    endfunction

    // ---------------- command text generation ----------------

    function automatic logic [CHAR_WIDTH-1:0] pick_letter();
        return CHAR_WIDTH'(($urandom_range(0, 1) ? 'h41 : 'h61) + $urandom_range(0, 25));
    endfunction

    function automatic logic [CHAR_WIDTH-1:0] pick_blank();
        int r;
        r = $urandom_range(0, 6);
        return (r > 4) ? CHAR_WIDTH'('h20) : CHAR_WIDTH'('h09 + r);
    endfunction

    function automatic logic [CHAR_WIDTH-1:0] pick_any();
        case ($urandom_range(0, 9))
            0, 1, 2: return CHAR_WIDTH'($urandom_range(0, 65535));
            3:       return pick_letter();
            4:       return pick_blank();
            5:       return CH_QUOTE;
            6:       return CH_BSLASH;
            7:       return CH_COMMA;
            8:       return ($urandom_range(0, 1) == 0) ? CH_LPAREN
                          : (($urandom_range(0, 1) == 0) ? CH_RPAREN : CH_SEMI);
            default: return CHAR_WIDTH'($urandom_range(0, 127));
        endcase
    endfunction

    function automatic void compose_command();
        repeat ($urandom_range(0, 2)) add_char(pick_blank());
        repeat ($urandom_range(1, 4)) add_char(pick_letter());
        add_char(CH_LPAREN);
        repeat ($urandom_range(0, 2)) begin
            repeat ($urandom_range(0, 2))
                add_char(($urandom_range(0, 1) == 0) ? CH_COMMA : pick_blank());
            add_char(CH_QUOTE);
            repeat ($urandom_range(0, 3)) begin
                case ($urandom_range(0, 6))
                    0, 1: add_char(pick_letter());
                    2:    add_char(pick_blank());
                    3:    add_char(CHAR_WIDTH'($urandom_range(0, 65535)));
                    4:    begin
                              add_char(CH_BSLASH);
                              add_char(CH_QUOTE);
                          end
                    5:    add_char(CH_BSLASH);
                    default: add_char(pick_any());
                endcase
            end
            add_char(CH_QUOTE);
        end
        if ($urandom_range(0, 2) == 0) add_char(pick_blank());
        add_char(CH_RPAREN);
        if ($urandom_range(0, 2) == 0) add_char(pick_blank());
        add_char(CH_SEMI);
    endfunction

    // Mostly well-formed command lines, some cut short or corrupted, a few pure noise.
    function automatic void compose_text();
        int keep;
        line_chars.delete();
        if ($urandom_range(0, 6) == 0) begin
            repeat ($urandom_range(1, 5)) add_char(pick_any());
        end
        else begin
            repeat ($urandom_range(1, 2)) compose_command();
            if ($urandom_range(0, 3) == 0) add_char(pick_blank());
            case ($urandom_range(0, 5))
                0: begin
                       keep = $urandom_range(1, line_chars.size());
                       while (line_chars.size() > keep) void'(line_chars.pop_back());
                   end
                1: line_chars[$urandom_range(0, line_chars.size() - 1)] = pick_any();
                default: ;
            endcase
        end
    endfunction

    // ---------------- sender ----------------

    task automatic send_char(input logic [CHAR_WIDTH-1:0] code, input logic eot,
                             input logic typed, input token_t tok);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                push <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        push        <= 1'b1;
        char_code   <= code;
        end_of_text <= eot;
        drv_typed   <= typed;
        drv_token   <= tok;
        do @(posedge clk); while (full);
    endtask

    task automatic hold_until_drained();
        push <= 1'b0;
        @(posedge clk);
        while (tokens_due.size() != 0) @(posedge clk);
    endtask

    initial begin
        int waited;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (SCRIPT[i])
            send_char(SCRIPT[i].code, SCRIPT[i].eot, SCRIPT[i].typed, SCRIPT[i].tok);
        hold_until_drained();

        while (live_chars < 460) begin
            compose_text();
            foreach (line_chars[i])
                send_char(line_chars[i], i == line_chars.size() - 1, 1'b0, NO_TOKEN);
            if ($urandom_range(0, 7) == 0)
                hold_until_drained();
        end

        push <= 1'b0;
        waited = 0;
        @(posedge clk);
        while (tokens_due.size() != 0 && waited < 5000) begin
            @(posedge clk);
            waited++;
        end
        repeat (32) @(posedge clk);
        if (tokens_due.size() != 0) begin
            $error("%0d expected results never arrived", tokens_due.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // ---------------- receiver ----------------

    // Rotate through free-running, random, heavy-stall and periodic-stall patterns.
    always @(posedge clk) begin
        rx_tick <= rx_tick + 16'd1;
        case (rx_tick[7:6])
            2'd0:    pop <= 1'b1;
            2'd1:    pop <= 1'($urandom_range(0, 1));
            2'd2:    pop <= ($urandom_range(0, 3) == 0);
            default: pop <= (rx_tick[2:0] != 3'd5);
        endcase
    end

    // ---------------- monitor and checker ----------------

    function automatic void check_field(input string field, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 'h%0h, got 'h%0h", field, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk) begin
        token_t want;
        if (rst_n) begin
            if (push && !full) begin
                live_chars++;
                tokenize_char(char_code, end_of_text);
                if (drv_typed)
                    tokens_due.insert(tokens_due.size(), drv_token);
                else
                    foreach (char_tokens[i]) tokens_due.insert(tokens_due.size(), char_tokens[i]);
            end
            if (pop && !empty) begin
                if (tokens_due.size() == 0) begin
                    $error("result transfer with nothing expected: event_kind %0d char_out 'h%0h",
                           event_kind, char_out);
                    mismatches++;
                end
                else begin
                    want = tokens_due.pop_front();
                    check_field("event_kind", 32'(want.kind), 32'(event_kind));
                    check_field("char_out", 32'(want.ch), 32'(char_out));
                    check_field("error_code", 32'(want.err), 32'(error_code));
                    check_field("final_res", 32'(want.fin), 32'(final_res));
                end
            end
        end
    end

endmodule
